// ===== design/dtsl_pkg.sv =====
// ----------------------------------------------------------------------------
// dtsl_pkg
// Shared types, codes and tables for the decimal segment LCD writer.
// ----------------------------------------------------------------------------
package dtsl_pkg;

  localparam int DIGITS_DEF = 6;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Reciprocal of ten for a 32-bit dividend: q = (v * RECIP10) >> RECIP_SHIFT
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [1:0] ACT_NUMBER = 2'd0;
  localparam logic [1:0] ACT_DASH   = 2'd1;
  localparam logic [1:0] ACT_DBAR   = 2'd2;

  localparam logic [3:0] SYM_DASH = 4'd10;
  localparam logic [3:0] SYM_DBAR = 4'd11;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic       clear_all;
    logic [5:0] segment_line;
    logic [3:0] nibble;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    KIND_NUMBER,
    KIND_DASH,
    KIND_DBAR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_LOW,
    BK_HIGH
  } bk_state_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] sym);
    logic [7:0] pat;
    unique case (sym)
      4'd0:    pat = 8'hfc;
      4'd1:    pat = 8'h60;
      4'd2:    pat = 8'hdb;
      4'd3:    pat = 8'hf3;
      4'd4:    pat = 8'h67;
      4'd5:    pat = 8'hb7;
      4'd6:    pat = 8'hbf;
      4'd7:    pat = 8'he4;
      4'd8:    pat = 8'hff;
      4'd9:    pat = 8'hf7;
      4'd10:   pat = 8'h03;
      4'd11:   pat = 8'h90;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  function automatic logic [5:0] first_line(input logic [2:0] pos);
    logic [5:0] line;
    unique case (pos)
      3'd0:    line = 6'd14;
      3'd1:    line = 6'd28;
      3'd2:    line = 6'd36;
      3'd3:    line = 6'd6;
      3'd4:    line = 6'd10;
      3'd5:    line = 6'd18;
      default: line = 6'd0;
    endcase
    return line;
  endfunction

endpackage

// ===== design/decimal_to_segment_lcd_writer.sv =====
// ----------------------------------------------------------------------------
// decimal_to_segment_lcd_writer
// Turns show-number and fill-pattern commands into segment memory writes
// for a six-digit segment LCD.
// ----------------------------------------------------------------------------
//
// Channel   Signals                    Direction  Handshake
// -------   -------------------------  ---------  ------------------------------
// command   start, busy, cmd           in         taken when start && !busy
// write     strobe, result             out        one write per strobe, no stall
//
// Writes: a number command yields one clear write and two writes per shown
// digit (3 to 13 writes); a pattern command yields two writes per digit.
// The back-end sequencer emits one write per cycle while it works through a
// command and passes through its idle state to take the next command from
// the queue; the one-write-per-cycle output sets this pace, and one shared
// divide-by-ten multiplier keeps up.
// Reset clears the queue and returns the sequencer to idle.
// busy rises only when the two-entry command queue is full; the receiver
// of writes cannot stall, so writes flow out at the sequencer's pace.
// The unused action code is taken and dropped without writes.
//
module decimal_to_segment_lcd_writer #(
  parameter int DIGITS = dtsl_pkg::DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dtsl_pkg::cmd_t cmd,
  output logic           strobe,
  output dtsl_pkg::res_t result
);
  import dtsl_pkg::*;

  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  // Front: take and classify commands, hold them until the sequencer is free.
  dtsl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  // Back: turn one queued command into low and high nibble writes, after a clear for numbers.
  dtsl_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .strobe  (strobe),
    .result  (result)
  );

`ifndef SYNTHESIS
  // A clear write carries no line, nibble or end mark.
  a_clear_clean: assert property (@(posedge clk) disable iff (rst)
    strobe && result.clear_all |->
      result.segment_line == 6'd0 && result.nibble == 4'd0 && !result.last)
    else $error("clear write carries stray fields");

  // A clear is always followed by a digit write.
  a_clear_then_digit: assert property (@(posedge clk) disable iff (rst)
    strobe && result.clear_all |=> strobe && !result.clear_all)
    else $error("clear not followed by a digit write");

  // A low-nibble write is followed by the same digit's second line.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.clear_all && !result.segment_line[0] |=>
      strobe && !result.clear_all &&
      result.segment_line == 6'($past(result.segment_line) + 6'd1))
    else $error("digit writes not paired");
`endif

endmodule

// ===== design/dtsl_front.sv =====
// ----------------------------------------------------------------------------
// dtsl_front
// Accepts commands, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module dtsl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dtsl_pkg::cmd_t   cmd,
  output logic            q_valid,
  output dtsl_pkg::entry_t q_entry,
  input  logic            q_pop
);
  import dtsl_pkg::*;

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              known;
  logic              push;
  entry_t            classified;

  // Classify; the unused action code is accepted and dropped.
  always_comb begin
    known           = 1'b1;
    classified.kind  = KIND_NUMBER;
    classified.value = cmd.value;
    unique case (cmd.action)
      ACT_NUMBER: classified.kind = KIND_NUMBER;
      ACT_DASH:   classified.kind = KIND_DASH;
      ACT_DBAR:   classified.kind = KIND_DBAR;
      default:    known = 1'b0;
    endcase
  end

  assign busy    = (count == QCNT_W'(QDEPTH));
  assign push    = start && !busy && known;
  assign q_valid = (count != '0);
  assign q_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

endmodule

// ===== design/dtsl_back.sv =====
// ----------------------------------------------------------------------------
// dtsl_back
// Sequencer that turns one queued command into segment memory writes.
// ----------------------------------------------------------------------------
module dtsl_back #(
  parameter int DIGITS = dtsl_pkg::DIGITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  dtsl_pkg::entry_t q_entry,
  output logic            q_pop,
  output logic            strobe,
  output dtsl_pkg::res_t   result
);
  import dtsl_pkg::*;

  localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  bk_state_t        state;
  bk_state_t        state_next;
  kind_t            kind;
  logic [31:0]      v;
  logic [31:0]      q;
  logic [3:0]       d;
  logic [POS_W-1:0] pos;

  logic [31:0] mul_in;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  digit_now;
  logic [3:0]  sym_low;
  logic [7:0]  pat_low;
  logic [7:0]  pat_high;
  logic [5:0]  line;
  logic        is_last;

  // Shared divide-by-ten: the dividend is v on the clear write, q afterwards.
  assign mul_in    = (state == BK_CLEAR) ? v : q;
  assign prod      = 64'(mul_in) * 64'(RECIP10);
  assign quot      = 32'(prod >> RECIP_SHIFT);
  assign digit_now = 4'(v - (q << 3) - (q << 1));

  always_comb begin
    unique case (kind)
      KIND_DASH: sym_low = SYM_DASH;
      KIND_DBAR: sym_low = SYM_DBAR;
      default:   sym_low = digit_now;
    endcase
  end

  assign pat_low  = seg_pattern(sym_low);
  assign pat_high = seg_pattern(d);
  assign line     = first_line(3'(pos));
  // In the high write v already holds what is left after this digit.
  assign is_last  = (pos == POS_W'(DIGITS - 1)) || (kind == KIND_NUMBER && v == '0);
  assign q_pop    = (state == BK_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = (q_entry.kind == KIND_NUMBER) ? BK_CLEAR : BK_LOW;
        end
      end
      BK_CLEAR: state_next = BK_LOW;
      BK_LOW:   state_next = BK_HIGH;
      BK_HIGH:  state_next = is_last ? BK_IDLE : BK_LOW;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    strobe = 1'b0;
    result = '0;
    unique case (state)
      BK_IDLE: ;
      BK_CLEAR: begin
        strobe           = 1'b1;
        result.clear_all = 1'b1;
      end
      BK_LOW: begin
        strobe              = 1'b1;
        result.segment_line = line;
        result.nibble       = pat_low[3:0];
      end
      BK_HIGH: begin
        strobe              = 1'b1;
        result.segment_line = line + 6'd1;
        result.nibble       = pat_high[7:4];
        result.last         = is_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        pos <= '0;
      end else if (state == BK_HIGH && !is_last) begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          kind <= q_entry.kind;
          v    <= q_entry.value;
        end
      end
      BK_CLEAR: q <= quot;
      BK_LOW: begin
        d <= sym_low;
        v <= q;
        q <= quot;
      end
      default: ;
    endcase
  end

endmodule
